[hdl/rcsp_pkg.sv]
// rcsp_pkg: shared types, constants and helper functions for the round cone
// support point pipeline. No dependencies.
`default_nettype none

package rcsp_pkg;

  localparam int DATA_W     = 32;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_FRONT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_BACK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_DISTANCE = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic              front;
    logic              n_zero;
    logic [2:0]        neg;
    logic [DATA_W-1:0] n;
  } div_ctl_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'h8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[hdl/round_cone_support_point_top.sv]
// round_cone_support_point_top: support point of a round cone for a query vector,
// fully pipelined (square, sum, bit-serial sqrt, decision, long division, saturate).
// Depends on rcsp_pkg.
//
//  channel  ports                                        transaction
//  in       start, busy, in_direction_x/y/z              start && !busy
//  out      out_valid, out_support_x/y/z, out_front_chosen  out_valid (one cycle)
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// one transaction enters per cycle. most of the pipeline is made of the 32 one-bit
// stages of the square root and the 31 one-bit stages of the three parallel
// dividers. busy and cfg_ready are constant, the receiver cannot stall, so nothing
// ever holds. reset (rst_n low, synchronous) clears all valid bits and loads 1.0
// into the three registers.
`default_nettype none

module round_cone_support_point_top #(
  parameter int FRAC_BITS = rcsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [rcsp_pkg::DATA_W-1:0] in_direction_x,
  input  wire logic signed [rcsp_pkg::DATA_W-1:0] in_direction_y,
  input  wire logic signed [rcsp_pkg::DATA_W-1:0] in_direction_z,
  output logic                               out_valid,
  output logic signed [rcsp_pkg::DATA_W-1:0] out_support_x,
  output logic signed [rcsp_pkg::DATA_W-1:0] out_support_y,
  output logic signed [rcsp_pkg::DATA_W-1:0] out_support_z,
  output logic                               out_front_chosen,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcsp_pkg::REG_W-1:0]    cfg_data
);
  import rcsp_pkg::*;

  localparam logic [REG_W-1:0] ONE = REG_W'(1) << FRAC_BITS;

  // configuration
  logic [REG_W-1:0] rf_r, rb_r, len_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r  <= ONE;
      rb_r  <= ONE;
      len_r <= ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIUS_FRONT:    rf_r  <= cfg_data;
        CFG_RADIUS_BACK:     rb_r  <= cfg_data;
        CFG_CENTRE_DISTANCE: len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: squares
  logic              a_v_r;
  vec_t              a_vec_r;
  logic [63:0]       a_sqx_r, a_sqy_r, a_sqz_r;
  logic [DATA_W-1:0] mx, my, mz;

  assign mx = mag32(in_direction_x);
  assign my = mag32(in_direction_y);
  assign mz = mag32(in_direction_z);

  // sqrt pipeline, index 0 is the sum stage
  logic        sq_v_r   [0:SQRT_STEPS];
  logic [63:0] sq_rem_r [0:SQRT_STEPS];
  logic [63:0] sq_res_r [0:SQRT_STEPS];
  vec_t        sq_vec_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else begin
      a_v_r    <= start && !busy;
      sq_v_r[0] <= a_v_r;
    end
    a_vec_r     <= '{x: in_direction_x, y: in_direction_y, z: in_direction_z};
    a_sqx_r     <= 64'(mx) * 64'(mx);
    a_sqy_r     <= 64'(my) * 64'(my);
    a_sqz_r     <= 64'(mz) * 64'(mz);
    sq_rem_r[0] <= a_sqx_r + a_sqy_r + a_sqz_r;
    sq_res_r[0] <= '0;
    sq_vec_r[0] <= a_vec_r;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] trial;
    logic [63:0] rem_nxt, res_nxt;

    always_comb begin
      trial = sq_res_r[j] + BIT;
      if (sq_rem_r[j] >= trial) begin
        rem_nxt = sq_rem_r[j] - trial;
        res_nxt = (sq_res_r[j] >> 1) + BIT;
      end else begin
        rem_nxt = sq_rem_r[j];
        res_nxt = sq_res_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
      sq_rem_r[j+1] <= rem_nxt;
      sq_res_r[j+1] <= res_nxt;
      sq_vec_r[j+1] <= sq_vec_r[j];
    end
  end

  // stage c: decision products
  logic [DATA_W-1:0]        n_w;
  logic signed [DATA_W-1:0] d_w;
  logic [DATA_W-1:0]        dmag_w;

  assign n_w    = sq_res_r[SQRT_STEPS][DATA_W-1:0];
  assign d_w    = $signed({1'b0, rb_r}) - $signed({1'b0, rf_r});
  assign dmag_w = mag32(d_w);

  logic               c_v_r, c_cone_r, c_dneg_r;
  logic signed [64:0] c_dn_r;
  logic signed [63:0] c_pl_r;
  logic [DATA_W-1:0]  c_n_r;
  vec_t               c_vec_r;

  // stage d: sphere choice
  logic              d_v_r, d_front_r;
  logic [REG_W-1:0]  d_r_r;
  logic [DATA_W-1:0] d_n_r;
  vec_t              d_vec_r;
  logic              front_w;

  always_comb begin
    if (c_cone_r) begin
      front_w = (c_n_r == '0) ? c_dneg_r : (c_dn_r < 65'(c_pl_r));
    end else begin
      front_w = rb_r < rf_r;
    end
  end

  // stage e: numerator products
  logic              e_v_r, e_front_r;
  logic [62:0]       e_px_r, e_py_r, e_pz_r;
  logic [DATA_W-1:0] e_n_r;
  logic [2:0]        e_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      c_v_r <= sq_v_r[SQRT_STEPS];
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
    c_cone_r  <= {1'b0, dmag_w[REG_W-1:0]} < {1'b0, len_r};
    c_dneg_r  <= d_w[DATA_W-1];
    c_dn_r    <= 65'(d_w) * $signed({33'd0, n_w});
    c_pl_r    <= 64'(sq_vec_r[SQRT_STEPS].z) * $signed({33'd0, len_r});
    c_n_r     <= n_w;
    c_vec_r   <= sq_vec_r[SQRT_STEPS];
    d_front_r <= front_w;
    d_r_r     <= front_w ? rf_r : rb_r;
    d_n_r     <= c_n_r;
    d_vec_r   <= c_vec_r;
    e_front_r <= d_front_r;
    e_px_r    <= 63'(mag32(d_vec_r.x)) * 63'(d_r_r);
    e_py_r    <= 63'(mag32(d_vec_r.y)) * 63'(d_r_r);
    e_pz_r    <= 63'(mag32(d_vec_r.z)) * 63'(d_r_r);
    e_n_r     <= d_n_r;
    e_neg_r   <= {d_vec_r.x[DATA_W-1], d_vec_r.y[DATA_W-1], d_vec_r.z[DATA_W-1]};
  end

  // long division, three lanes, one quotient bit a stage
  logic              dv_v_r   [0:DIV_STEPS];
  logic [DATA_W-1:0] dv_rem_r [0:DIV_STEPS][0:2];
  logic [REG_W-1:0]  dv_num_r [0:DIV_STEPS][0:2];
  logic [REG_W-1:0]  dv_q_r   [0:DIV_STEPS][0:2];
  div_ctl_t          dv_ctl_r [0:DIV_STEPS];
  logic [62:0]       numer    [0:2];

  assign numer[0] = e_px_r + 63'(e_n_r >> 1);
  assign numer[1] = e_py_r + 63'(e_n_r >> 1);
  assign numer[2] = e_pz_r + 63'(e_n_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= e_v_r;
    end
    for (int l = 0; l < 3; l++) begin
      dv_rem_r[0][l] <= numer[l][62:31];
      dv_num_r[0][l] <= numer[l][30:0];
      dv_q_r[0][l]   <= '0;
    end
    dv_ctl_r[0] <= '{front: e_front_r, n_zero: (e_n_r == '0), neg: e_neg_r, n: e_n_r};
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DATA_W:0]   t     [0:2];
    logic              ge    [0:2];
    logic [DATA_W-1:0] rem_nxt [0:2];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]       = {dv_rem_r[k][l], dv_num_r[k][l][REG_W-1]};
        ge[l]      = t[l] >= {1'b0, dv_ctl_r[k].n};
        rem_nxt[l] = ge[l] ? DATA_W'(t[l] - {1'b0, dv_ctl_r[k].n}) : t[l][DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      for (int l = 0; l < 3; l++) begin
        dv_rem_r[k+1][l] <= rem_nxt[l];
        dv_num_r[k+1][l] <= dv_num_r[k][l] << 1;
        dv_q_r[k+1][l]   <= {dv_q_r[k][l][REG_W-2:0], ge[l]};
      end
      dv_ctl_r[k+1] <= dv_ctl_r[k];
    end
  end

  // output stage: sign, centre offset, saturation
  div_ctl_t           fc;
  logic signed [33:0] sv  [0:2];
  logic signed [33:0] off;

  assign fc  = dv_ctl_r[DIV_STEPS];
  assign off = $signed({4'd0, len_r[REG_W-1:1]});

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sv[l] = fc.n_zero ? 34'sd0 : $signed({3'd0, dv_q_r[DIV_STEPS][l]});
      if (fc.neg[2-l]) begin
        sv[l] = -sv[l];
      end
    end
    sv[2] = fc.front ? (sv[2] + off) : (sv[2] - off);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v_r[DIV_STEPS];
    end
    out_support_x    <= sat32(sv[0]);
    out_support_y    <= sat32(sv[1]);
    out_support_z    <= sat32(sv[2]);
    out_front_chosen <= fc.front;
  end

endmodule

`default_nettype wire
